[rtl/ilnorm_pkg.sv]
`timescale 1ns / 1ps

package ilnorm_pkg;

    // Position width is fixed by the result fields.
    localparam int POS_BITS         = 15;
    localparam int IN_BITS          = 16;
    localparam int MAX_SEGMENTS_DEF = 16;

    typedef logic [POS_BITS-1:0] pos_t;

    typedef struct packed {
        logic signed [IN_BITS-1:0] range_start;
        logic signed [IN_BITS-1:0] range_end;
        logic                      last_in_list;
    } item_t;

    typedef struct packed {
        logic [POS_BITS-1:0] merged_start;
        logic [POS_BITS-1:0] merged_end;
        logic                final_segment;
        logic                list_empty;
        logic                table_overflow;
    } result_t;

    // One stored interval plus the flags latched at the last compare.
    typedef struct packed {
        logic valid;
        pos_t seg_start;
        pos_t seg_end;
        logic touch;
        logic above;
    } seg_t;

    typedef enum logic [1:0] {
        CMD_HOLD,
        CMD_INSERT,
        CMD_COLLAPSE,
        CMD_SHIFT
    } cmd_op_t;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        cmd_op_t op;
        pos_t    new_start;
        pos_t    new_end;
        logic    table_full;
    } cmd_t;

endpackage

[rtl/ilnorm_cell.sv]
`timescale 1ns / 1ps

module ilnorm_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  ilnorm_pkg::cmd_t   cmd,
    input  logic               merge_any,
    input  ilnorm_pkg::seg_t   left_seg,
    input  logic               left_gt,
    input  ilnorm_pkg::seg_t   right_seg,
    output ilnorm_pkg::seg_t   seg,
    output logic               gt,
    output logic               hit
);

    ilnorm_pkg::seg_t seg_reg;
    ilnorm_pkg::seg_t seg_next;
    logic             below;
    logic             above;

    assign below = seg_reg.valid && (seg_reg.seg_end < cmd.new_start);
    assign above = seg_reg.valid && (seg_reg.seg_start > cmd.new_end);
    assign hit   = seg_reg.valid && !below && !above;
    // new interval belongs at or before this cell
    assign gt    = above || !seg_reg.valid;
    assign seg   = seg_reg;

    always_comb
    begin
        seg_next = seg_reg;
        unique case (cmd.op)
            ilnorm_pkg::CMD_HOLD:
            begin
            end
            ilnorm_pkg::CMD_INSERT:
            begin
                if (merge_any)
                begin
                    seg_next.touch = hit;
                    seg_next.above = above;
                    if (hit)
                    begin
                        if (cmd.new_start < seg_reg.seg_start)
                            seg_next.seg_start = cmd.new_start;
                        if (cmd.new_end > seg_reg.seg_end)
                            seg_next.seg_end = cmd.new_end;
                    end
                end
                else if (!cmd.table_full)
                begin
                    if (left_gt && left_seg.valid)
                        seg_next = left_seg;
                    else if (gt && !left_gt)
                    begin
                        seg_next.valid     = 1'b1;
                        seg_next.seg_start = cmd.new_start;
                        seg_next.seg_end   = cmd.new_end;
                    end
                    seg_next.touch = 1'b0;
                    seg_next.above = 1'b0;
                end
            end
            ilnorm_pkg::CMD_COLLAPSE:
            begin
                // first cell of the touched run swallows its right neighbor,
                // the rest of the run and everything above slide down
                if (seg_reg.touch && !left_seg.touch)
                    seg_next.seg_end = right_seg.seg_end;
                else if ((seg_reg.touch && left_seg.touch) || seg_reg.above)
                    seg_next = right_seg;
            end
            ilnorm_pkg::CMD_SHIFT:
            begin
                seg_next = right_seg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seg_reg <= '0;
        else
            seg_reg <= seg_next;
    end

endmodule

[rtl/interval_list_normalizer.sv]
`timescale 1ns / 1ps

// Closed-interval list merger.
// Input channel (item_valid / item_stall / item): one interval per transfer,
// last_in_list on the final one. Intervals with a negative bound or with
// start above end are discarded.
// Output channel (result_valid / result_stall / result): after the last item
// the merged, disjoint intervals leave in ascending order, final_segment on
// the last; an empty table gives one transfer with list_empty set.
// table_overflow is repeated on every result of the list.
// Flow: an item is accepted in S_IDLE, then compared against all cells in
// parallel in S_INSERT and inserted or absorbed; each additional stored
// interval that the same item bridges adds an S_COLLAPSE step, as the cell
// chain removes one merged entry per cycle. item_stall is high outside S_IDLE,
// so a new item waits until the last is through. Emission shifts the chain by
// one cell per result; the first result is loaded in S_EMIT, after S_INSERT
// and any S_COLLAPSE steps for the final item. The output register lets the
// next list start while the final result still waits on result_stall.
// Reset: asynchronous, empties the chain at once; no clearing pass.
module interval_list_normalizer #(
    parameter int MAX_SEGMENTS = ilnorm_pkg::MAX_SEGMENTS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  ilnorm_pkg::item_t   item,
    output logic                result_valid,
    input  logic                result_stall,
    output ilnorm_pkg::result_t result
);

    typedef enum logic [3:0] {
        S_IDLE     = 4'b0001,
        S_INSERT   = 4'b0010,
        S_COLLAPSE = 4'b0100,
        S_EMIT     = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    ilnorm_pkg::pos_t    new_start_reg, new_start_next;
    ilnorm_pkg::pos_t    new_end_reg, new_end_next;
    logic                int_ok_reg, int_ok_next;
    logic                last_reg, last_next;
    logic                ovf_reg, ovf_next;
    logic                result_valid_reg, result_valid_next;
    ilnorm_pkg::result_t result_reg, result_next;

    ilnorm_pkg::cmd_t    cmd;
    ilnorm_pkg::seg_t    seg_q [MAX_SEGMENTS];
    logic [MAX_SEGMENTS-1:0] gt_vec;
    logic [MAX_SEGMENTS-1:0] hit_vec;
    logic [MAX_SEGMENTS-1:0] valid_vec;

    logic item_ok;
    logic item_xfer;
    logic out_load;
    logic hit_any;
    logic pair_hit;
    logic more_pairs;

    // ------------------------------------------------------------------
    // Input checks: both bounds non-negative and in the position range,
    // start not above end.
    // ------------------------------------------------------------------
    assign item_ok = !item.range_start[ilnorm_pkg::IN_BITS-1]
                  && (item.range_end[ilnorm_pkg::IN_BITS-1:ilnorm_pkg::POS_BITS] == '0)
                  && (item.range_start <= item.range_end);

    assign item_stall   = (state_reg != S_IDLE);
    assign item_xfer    = item_valid && !item_stall;
    assign out_load     = !result_valid_reg || !result_stall;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // ------------------------------------------------------------------
    // Cell chain
    // ------------------------------------------------------------------
    always_comb
    begin
        cmd.new_start  = new_start_reg;
        cmd.new_end    = new_end_reg;
        cmd.table_full = valid_vec[MAX_SEGMENTS-1];
        cmd.op         = ilnorm_pkg::CMD_HOLD;
        unique case (state_reg)
            S_IDLE:     cmd.op = ilnorm_pkg::CMD_HOLD;
            S_INSERT:   cmd.op = int_ok_reg ? ilnorm_pkg::CMD_INSERT : ilnorm_pkg::CMD_HOLD;
            S_COLLAPSE: cmd.op = ilnorm_pkg::CMD_COLLAPSE;
            S_EMIT:     cmd.op = out_load ? ilnorm_pkg::CMD_SHIFT : ilnorm_pkg::CMD_HOLD;
            default:    cmd.op = ilnorm_pkg::CMD_HOLD;
        endcase
    end

    for (genvar i = 0; i < MAX_SEGMENTS; i++)
    begin : g_cell
        ilnorm_pkg::seg_t left_seg;
        ilnorm_pkg::seg_t right_seg;
        logic             left_gt;

        if (i == 0)
        begin : g_first
            assign left_seg = '0;
            assign left_gt  = 1'b0;
        end
        else
        begin : g_mid
            assign left_seg = seg_q[i-1];
            assign left_gt  = gt_vec[i-1];
        end

        if (i == MAX_SEGMENTS - 1)
        begin : g_last
            assign right_seg = '0;
        end
        else
        begin : g_inner
            assign right_seg = seg_q[i+1];
        end

        ilnorm_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cmd),
            .merge_any (hit_any),
            .left_seg  (left_seg),
            .left_gt   (left_gt),
            .right_seg (right_seg),
            .seg       (seg_q[i]),
            .gt        (gt_vec[i]),
            .hit       (hit_vec[i])
        );

        assign valid_vec[i] = seg_q[i].valid;
    end

    assign hit_any = |hit_vec;

    // Touched run longer than one cell needs collapse cycles.
    always_comb
    begin
        pair_hit   = 1'b0;
        more_pairs = 1'b0;
        for (int i = 0; i + 1 < MAX_SEGMENTS; i++)
            pair_hit = pair_hit | (hit_vec[i] & hit_vec[i+1]);
        // after this collapse step another pair remains
        for (int i = 0; i + 2 < MAX_SEGMENTS; i++)
            more_pairs = more_pairs
                       | (seg_q[i].touch & seg_q[i+1].touch & seg_q[i+2].touch);
    end

    // ------------------------------------------------------------------
    // Control
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next        = state_reg;
        new_start_next    = new_start_reg;
        new_end_next      = new_end_reg;
        int_ok_next       = int_ok_reg;
        last_next         = last_reg;
        ovf_next          = ovf_reg;
        result_valid_next = result_valid_reg;
        result_next       = result_reg;

        if (out_load)
            result_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_xfer)
                begin
                    new_start_next = item.range_start[ilnorm_pkg::POS_BITS-1:0];
                    new_end_next   = item.range_end[ilnorm_pkg::POS_BITS-1:0];
                    int_ok_next    = item_ok;
                    last_next      = item.last_in_list;
                    state_next     = S_INSERT;
                end
            end
            S_INSERT:
            begin
                if (int_ok_reg && !hit_any && valid_vec[MAX_SEGMENTS-1])
                    ovf_next = 1'b1;
                if (int_ok_reg && pair_hit)
                    state_next = S_COLLAPSE;
                else if (last_reg)
                    state_next = S_EMIT;
                else
                    state_next = S_IDLE;
            end
            S_COLLAPSE:
            begin
                if (!more_pairs)
                    state_next = last_reg ? S_EMIT : S_IDLE;
            end
            S_EMIT:
            begin
                if (out_load)
                begin
                    result_valid_next          = 1'b1;
                    result_next.table_overflow = ovf_reg;
                    if (seg_q[0].valid)
                    begin
                        result_next.merged_start  = seg_q[0].seg_start;
                        result_next.merged_end    = seg_q[0].seg_end;
                        result_next.final_segment = !seg_q[1].valid;
                        result_next.list_empty    = 1'b0;
                    end
                    else
                    begin
                        result_next.merged_start  = '0;
                        result_next.merged_end    = '0;
                        result_next.final_segment = 1'b1;
                        result_next.list_empty    = 1'b1;
                    end
                    if (result_next.final_segment)
                    begin
                        ovf_next   = 1'b0;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            ovf_reg          <= 1'b0;
            result_valid_reg <= 1'b0;
            int_ok_reg       <= 1'b0;
            last_reg         <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            ovf_reg          <= ovf_next;
            result_valid_reg <= result_valid_next;
            int_ok_reg       <= int_ok_next;
            last_reg         <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        new_start_reg <= new_start_next;
        new_end_reg   <= new_end_next;
        result_reg    <= result_next;
    end

`ifndef SYNTHESIS
    // occupied cells always form a run starting at cell 0
    a_chain_packed: assert property (@(posedge clk) disable iff (!rst_n)
        ((valid_vec & (valid_vec + {{(MAX_SEGMENTS-1){1'b0}}, 1'b1})) == '0))
        else $error("cell chain has a gap");

    a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg == S_EMIT))
        else $error("result raised outside emission");

    a_empty_after_final: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && out_load && result_next.final_segment)
        |=> (valid_vec == '0))
        else $error("table not empty after final result");

    a_overflow_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ovf_reg) |-> $past(valid_vec[MAX_SEGMENTS-1]))
        else $error("overflow flagged with free cells");
`endif

endmodule
